/* src/fk6_pkg.sv */
package fk6_pkg;

  // Formats
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 16;
  localparam int CORDIC_STEPS    = 18;
  localparam int ANG_W  = ANGLE_FRAC_BITS + 4;   // signed Q3.x joint angle
  localparam int OUT_W  = OUT_FRAC_BITS + 2;     // signed Q1.x rotation and Q1.x position results
  localparam int IFB    = 30;                    // internal fraction bits
  localparam int QW     = IFB + 3;               // internal word, holds +-4
  localparam int PW     = 2 * QW;                // product of two words
  localparam int SW     = PW + 2;                // sum of three products
  localparam int FW     = IFB + 5;               // widened angle before folding
  localparam int NJ     = 6;                     // joints
  localparam int OSH    = IFB - OUT_FRAC_BITS;   // final rounding shift

  // Q30 constants
  localparam longint PI_Q         = 64'sd3373259426;
  localparam longint HALF_PI_Q    = 64'sd1686629713;
  localparam longint TWO_PI_Q     = 64'sd6746518852;
  localparam longint QUARTER_PI_Q = 64'sd843314857;
  localparam longint GAIN_Q       = 64'sd652032874;
  localparam longint TWIST_Q      = 64'sd1686633657;
  localparam longint ONE_Q        = 64'sd1073741824;

  typedef logic signed [QW-1:0]    q_t;
  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [OUT_W-1:0] out_t;

  typedef struct packed {
    logic signed [63:0] s;
    logic signed [63:0] c;
  } sc64_t;

  // Fixed geometry of one link
  typedef struct packed {
    q_t a;
    q_t d;
    q_t sa;
    q_t ca;
  } link_const_t;

  // Link transform as produced by a lane
  typedef struct packed {
    q_t ct;
    q_t st;
    q_t a01;
    q_t a02;
    q_t a11;
    q_t a12;
    q_t a21;
    q_t a22;
    q_t v0;
    q_t v1;
    q_t v2;
  } link_mat_t;

  // Running pose: rotation and position
  typedef struct packed {
    q_t [2:0][2:0] r;
    q_t [2:0]      p;
  } pose_t;

  // atan(2^-i) in Q30, rounded; past step 10 it rounds to 2^-i exactly
  function automatic longint atan_q(input int i);
    longint r;
    case (i)
      0:       r = QUARTER_PI_Q;
      1:       r = 64'sd497837829;
      2:       r = 64'sd263043837;
      3:       r = 64'sd133525159;
      4:       r = 64'sd67021687;
      5:       r = 64'sd33543516;
      6:       r = 64'sd16775851;
      7:       r = 64'sd8388437;
      8:       r = 64'sd4194283;
      9:       r = 64'sd2097149;
      10:      r = 64'sd1048576;
      default: r = 64'sd1 <<< (IFB - i);
    endcase
    return r;
  endfunction

  // Sine and cosine of a fixed twist, same CORDIC as the lanes
  function automatic sc64_t twist_sc(input longint ang_in);
    longint ang;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic   neg;
    sc64_t  res;
    ang = ang_in;
    neg = 1'b0;
    if (ang > PI_Q) ang = ang - TWO_PI_Q;
    if (ang < -PI_Q) ang = ang + TWO_PI_Q;
    if (ang > HALF_PI_Q) begin
      ang = ang - PI_Q;
      neg = 1'b1;
    end else if (ang < -HALF_PI_Q) begin
      ang = ang + PI_Q;
      neg = 1'b1;
    end
    x = GAIN_Q;
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_q(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_q(i);
      end
    end
    res.c = neg ? -x : x;
    res.s = neg ? -y : y;
    return res;
  endfunction

  localparam sc64_t TW_POS  = twist_sc(TWIST_Q);
  localparam sc64_t TW_NEG  = twist_sc(-TWIST_Q);
  localparam sc64_t TW_ZERO = twist_sc(64'sd0);

  // Link table (a, twist, d)
  function automatic link_const_t link_c(input int j);
    link_const_t lc;
    lc.a  = '0;
    lc.d  = '0;
    lc.sa = q_t'(TW_ZERO.s);
    lc.ca = q_t'(TW_ZERO.c);
    case (j)
      0: begin
        lc.d  = q_t'(64'sd258234909);
        lc.sa = q_t'(TW_POS.s);
        lc.ca = q_t'(TW_POS.c);
      end
      1: begin
        lc.a  = q_t'(64'sd274877907);
      end
      2: begin
        lc.sa = q_t'(TW_POS.s);
        lc.ca = q_t'(TW_POS.c);
      end
      3: begin
        lc.d  = q_t'(-64'sd225485783);
        lc.sa = q_t'(TW_NEG.s);
        lc.ca = q_t'(TW_NEG.c);
      end
      4: begin
        lc.sa = q_t'(TW_POS.s);
        lc.ca = q_t'(TW_POS.c);
      end
      5: begin
        lc.d  = q_t'(-64'sd185220465);
      end
      default: begin
        lc.a = '0;
      end
    endcase
    return lc;
  endfunction

  // Round a Q60 sum back to Q30: add half, floor shift
  function automatic q_t rnd_q(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v + (SW'(1) <<< (IFB - 1));
    return q_t'(t >>> IFB);
  endfunction

  // Round Q30 to the output format and saturate
  function automatic out_t sat_o(input q_t v, input longint lo, input longint hi);
    logic signed [QW:0] t;
    logic signed [QW:0] s;
    t = (QW + 1)'(v) + ((QW + 1)'(1) <<< (OSH - 1));
    s = t >>> OSH;
    if (s < (QW + 1)'(lo)) return out_t'(lo);
    if (s > (QW + 1)'(hi)) return out_t'(hi);
    return out_t'(s);
  endfunction

  localparam longint RLIM = 64'sd1 <<< OUT_FRAC_BITS;
  localparam longint PLIM = 64'sd1 <<< (OUT_FRAC_BITS + 1);

endpackage

/* src/fk6_in_if.sv */
interface fk6_in_if;
  logic               valid;
  logic               ready;
  fk6_pkg::ang_t      base_angle;
  fk6_pkg::ang_t      shoulder_angle;
  fk6_pkg::ang_t      elbow_angle;
  fk6_pkg::ang_t      forearm_angle;
  fk6_pkg::ang_t      wrist_pitch_angle;
  fk6_pkg::ang_t      flange_angle;

  modport source (output valid, base_angle, shoulder_angle, elbow_angle, forearm_angle,
                  wrist_pitch_angle, flange_angle, input ready);
  modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, forearm_angle,
                  wrist_pitch_angle, flange_angle, output ready);
endinterface

/* src/fk6_out_if.sv */
interface fk6_out_if;
  logic          valid;
  logic          ready;
  fk6_pkg::out_t rot_r0c0;
  fk6_pkg::out_t rot_r0c1;
  fk6_pkg::out_t rot_r0c2;
  fk6_pkg::out_t rot_r1c0;
  fk6_pkg::out_t rot_r1c1;
  fk6_pkg::out_t rot_r1c2;
  fk6_pkg::out_t rot_r2c0;
  fk6_pkg::out_t rot_r2c1;
  fk6_pkg::out_t rot_r2c2;
  fk6_pkg::out_t pos_x;
  fk6_pkg::out_t pos_y;
  fk6_pkg::out_t pos_z;

  modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                  rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
                  rot_r2c0, rot_r2c1, rot_r2c2, pos_x, pos_y, pos_z, output ready);
endinterface

/* src/six_axis_dh_forward_kinematics_core.sv */
// Channel  Dir  Payload                                      Transaction
// in_i     in   six joint angles, signed Q3.16               valid & ready
// out_o    out  rotation Q1.16 (9), position Q1.16 (3)       valid & ready
//
// One pose per cycle while no result is held at the output; the latency is
// set by the CORDIC stages of the six joint lanes and the six merge stages.
// Reset clears only the valid pipeline and the output valid.
// A result held at the output stalls the whole pipeline; in_i.ready follows
// out_o.ready whenever a result is waiting.
module six_axis_dh_forward_kinematics_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  fk6_in_if.sink     in_i,
  fk6_out_if.source  out_o
);

  localparam int NJ  = fk6_pkg::NJ;
  localparam int LAT = fk6_pkg::CORDIC_STEPS + 3 + 2 * NJ;

  logic adv;
  logic out_valid_q;
  logic vld_q [LAT];

  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // Valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_i.valid;
      for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
      out_valid_q <= vld_q[LAT-1];
    end
  end

  fk6_pkg::ang_t ang [NJ];
  assign ang[0] = in_i.base_angle;
  assign ang[1] = in_i.shoulder_angle;
  assign ang[2] = in_i.elbow_angle;
  assign ang[3] = in_i.forearm_angle;
  assign ang[4] = in_i.wrist_pitch_angle;
  assign ang[5] = in_i.flange_angle;

  fk6_pkg::link_mat_t mat [NJ];
  fk6_pkg::pose_t     pose [NJ+1];

  // Identity pose into the first merge stage
  always_comb begin
    pose[0] = '0;
    for (int r = 0; r < 3; r++) pose[0].r[r][r] = fk6_pkg::q_t'(fk6_pkg::ONE_Q);
  end

  // Lanes, each later joint's angle delayed through a shift register to meet its merge stage
  for (genvar j = 0; j < NJ; j++) begin : g_joint
    fk6_pkg::ang_t lane_ang;
    if (j == 0) begin : g_direct
      assign lane_ang = ang[j];
    end else begin : g_skew
      fk6_pkg::ang_t dly_q [2*j];
      always_ff @(posedge clk_i) begin
        if (adv) begin
          dly_q[0] <= ang[j];
          for (int k = 1; k < 2 * j; k++) dly_q[k] <= dly_q[k-1];
        end
      end
      assign lane_ang = dly_q[2*j-1];
    end

    fk6_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (adv),
      .angle_i (lane_ang),
      .lc_i    (fk6_pkg::link_c(j)),
      .mat_o   (mat[j])
    );

    fk6_link u_link (
      .clk_i  (clk_i),
      .en_i   (adv),
      .pose_i (pose[j]),
      .mat_i  (mat[j]),
      .pose_o (pose[j+1])
    );
  end

  // Output register: round and saturate
  fk6_pkg::out_t rot_q [3][3];
  fk6_pkg::out_t pos_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        pos_q[r] <= fk6_pkg::sat_o(pose[NJ].p[r], -fk6_pkg::PLIM, fk6_pkg::PLIM - 1);
        for (int c = 0; c < 3; c++) begin
          rot_q[r][c] <= fk6_pkg::sat_o(pose[NJ].r[r][c], -fk6_pkg::RLIM, fk6_pkg::RLIM);
        end
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.rot_r0c0 = rot_q[0][0];
  assign out_o.rot_r0c1 = rot_q[0][1];
  assign out_o.rot_r0c2 = rot_q[0][2];
  assign out_o.rot_r1c0 = rot_q[1][0];
  assign out_o.rot_r1c1 = rot_q[1][1];
  assign out_o.rot_r1c2 = rot_q[1][2];
  assign out_o.rot_r2c0 = rot_q[2][0];
  assign out_o.rot_r2c1 = rot_q[2][1];
  assign out_o.rot_r2c2 = rot_q[2][2];
  assign out_o.pos_x    = pos_q[0];
  assign out_o.pos_y    = pos_q[1];
  assign out_o.pos_z    = pos_q[2];

  // A waiting result blocks new transactions
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while output stalled");

  // An accepted transaction enters the valid pipeline
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> vld_q[0])
    else $error("accepted transaction lost");

  // The first rotation entry stays inside the saturation range
  a_rot_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (rot_q[0][0] <= fk6_pkg::out_t'(fk6_pkg::RLIM))
                 && (rot_q[0][0] >= -fk6_pkg::out_t'(fk6_pkg::RLIM)))
    else $error("rotation entry beyond saturation limit");

endmodule

/* src/fk6_lane.sv */
// One joint: angle fold, pipelined CORDIC, link transform entries.
// Stages in order: folded angle, CORDIC steps, products, rounded entries; all advance on en_i.
module fk6_lane (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  fk6_pkg::ang_t         angle_i,
  input  fk6_pkg::link_const_t  lc_i,
  output fk6_pkg::link_mat_t    mat_o
);

  localparam int N = fk6_pkg::CORDIC_STEPS;
  localparam int FW = fk6_pkg::FW;
  localparam int PW = fk6_pkg::PW;
  localparam int SW = fk6_pkg::SW;
  localparam logic signed [FW-1:0] PI_F     = FW'(fk6_pkg::PI_Q);
  localparam logic signed [FW-1:0] HPI_F    = FW'(fk6_pkg::HALF_PI_Q);
  localparam logic signed [FW-1:0] TWOPI_F  = FW'(fk6_pkg::TWO_PI_Q);

  fk6_pkg::q_t x_q [N+1];
  fk6_pkg::q_t y_q [N+1];
  fk6_pkg::q_t z_q [N+1];
  logic        neg_q [N+1];

  // Fold the angle into [-pi/2, pi/2]
  logic signed [FW-1:0] th, t1, t2;
  logic                 neg_d;
  always_comb begin
    th = FW'(angle_i) <<< (fk6_pkg::IFB - fk6_pkg::ANGLE_FRAC_BITS);
    t1 = th;
    if (th > PI_F) t1 = th - TWOPI_F;
    else if (th < -PI_F) t1 = th + TWOPI_F;
    t2 = t1;
    neg_d = 1'b0;
    if (t1 > HPI_F) begin
      t2 = t1 - PI_F;
      neg_d = 1'b1;
    end else if (t1 < -HPI_F) begin
      t2 = t1 + PI_F;
      neg_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= fk6_pkg::q_t'(fk6_pkg::GAIN_Q);
      y_q[0]   <= '0;
      z_q[0]   <= fk6_pkg::q_t'(t2);
      neg_q[0] <= neg_d;
    end
  end

  // CORDIC rotation steps, one per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    localparam fk6_pkg::q_t AT = fk6_pkg::q_t'(fk6_pkg::atan_q(i));
    fk6_pkg::q_t dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + AT;
        end
      end
    end
  end

  // Undo the half-turn fold
  fk6_pkg::q_t ct, st;
  assign ct = neg_q[N] ? -x_q[N] : x_q[N];
  assign st = neg_q[N] ? -y_q[N] : y_q[N];

  // Products against twist and link length
  logic signed [PW-1:0] p_sca_q, p_ssa_q, p_cca_q, p_csa_q, p_act_q, p_ast_q;
  fk6_pkg::q_t ct_q, st_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ct_q    <= ct;
      st_q    <= st;
      p_sca_q <= st * lc_i.ca;
      p_ssa_q <= st * lc_i.sa;
      p_cca_q <= ct * lc_i.ca;
      p_csa_q <= ct * lc_i.sa;
      p_act_q <= lc_i.a * ct;
      p_ast_q <= lc_i.a * st;
    end
  end

  // Round into the transform entries
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_o.ct  <= ct_q;
      mat_o.st  <= st_q;
      mat_o.a01 <= -fk6_pkg::rnd_q(SW'(p_sca_q));
      mat_o.a02 <= fk6_pkg::rnd_q(SW'(p_ssa_q));
      mat_o.a11 <= fk6_pkg::rnd_q(SW'(p_cca_q));
      mat_o.a12 <= -fk6_pkg::rnd_q(SW'(p_csa_q));
      mat_o.a21 <= lc_i.sa;
      mat_o.a22 <= lc_i.ca;
      mat_o.v0  <= fk6_pkg::rnd_q(SW'(p_act_q));
      mat_o.v1  <= fk6_pkg::rnd_q(SW'(p_ast_q));
      mat_o.v2  <= lc_i.d;
    end
  end

endmodule

/* src/fk6_link.sv */
// Merge one link into the running pose: R' = R*A, P' = P + R*v.
// Registered in order: products, then sums with rounding.
module fk6_link (
  input  logic                clk_i,
  input  logic                en_i,
  input  fk6_pkg::pose_t      pose_i,
  input  fk6_pkg::link_mat_t  mat_i,
  output fk6_pkg::pose_t      pose_o
);

  localparam int PW = fk6_pkg::PW;
  localparam int SW = fk6_pkg::SW;

  fk6_pkg::q_t rm [3][3];
  fk6_pkg::q_t am [3][3];
  fk6_pkg::q_t vv [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rm[r][c] = pose_i.r[r][c];
      end
    end
    am[0][0] = mat_i.ct;  am[0][1] = mat_i.a01; am[0][2] = mat_i.a02;
    am[1][0] = mat_i.st;  am[1][1] = mat_i.a11; am[1][2] = mat_i.a12;
    am[2][0] = '0;        am[2][1] = mat_i.a21; am[2][2] = mat_i.a22;
    vv[0] = mat_i.v0;
    vv[1] = mat_i.v1;
    vv[2] = mat_i.v2;
  end

  // Products
  logic signed [PW-1:0] pm_q [3][3][3];
  logic signed [PW-1:0] pv_q [3][3];
  fk6_pkg::q_t          p_q [3];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        p_q[r] <= pose_i.p[r];
        for (int k = 0; k < 3; k++) begin
          pv_q[r][k] <= rm[r][k] * vv[k];
          for (int c = 0; c < 3; c++) begin
            pm_q[r][c][k] <= rm[r][k] * am[k][c];
          end
        end
      end
    end
  end

  // Sums, one rounding per entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        pose_o.p[r] <= p_q[r] + fk6_pkg::rnd_q(SW'(pv_q[r][0]) + SW'(pv_q[r][1])
                                               + SW'(pv_q[r][2]));
        for (int c = 0; c < 3; c++) begin
          pose_o.r[r][c] <= fk6_pkg::rnd_q(SW'(pm_q[r][c][0]) + SW'(pm_q[r][c][1])
                                           + SW'(pm_q[r][c][2]));
        end
      end
    end
  end

endmodule
